[src/afm_pkg.sv]
// Package: types, constants and codes shared by the adaptive frequency model.
`default_nettype none
package afm_pkg;

  localparam int CHAR_COUNT   = 256;
  localparam int SYMBOL_COUNT = 257;
  localparam int FREQ_LIMIT   = 16383;

  localparam int NUM_CELLS = SYMBOL_COUNT + 1;
  localparam int IDX_W     = $clog2(SYMBOL_COUNT + 1);
  localparam int CNT_W     = $clog2(FREQ_LIMIT + 1);
  localparam int CHR_W     = $clog2(CHAR_COUNT + 1);
  localparam int CHAR_W    = 8;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REINIT = 2'd2
  } afm_action_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_HALVE,
    ST_FIND,
    ST_APPLY,
    ST_READ,
    ST_WR1,
    ST_WR2,
    ST_OUT
  } afm_state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [8:0]        symbol_index;
    logic [CHAR_W-1:0] char_value;
  } afm_in_t;

  typedef struct packed {
    logic [8:0]  index_out;
    logic [13:0] cum_low;
    logic [13:0] cum_high;
    logic [13:0] total_count;
    logic        bad_request;
  } afm_out_t;

  // One model entry held by a cell.
  typedef struct packed {
    logic [CNT_W-1:0] freq;
    logic [CNT_W-1:0] cum;
    logic [CHR_W-1:0] chr;
  } afm_entry_t;

  typedef struct packed {
    logic shift;
    logic init;
  } afm_cell_ctrl_t;

endpackage
`default_nettype wire

[src/afm_cell.sv]
// One cell of the model ring: holds the entry for one index position.
`default_nettype none
module afm_cell (
  input  wire logic                    clk_i,
  input  wire afm_pkg::afm_cell_ctrl_t ctrl_i,
  input  wire logic [afm_pkg::IDX_W-1:0] idx_i,
  input  wire afm_pkg::afm_entry_t     ent_i,
  output afm_pkg::afm_entry_t          ent_o
);
  import afm_pkg::*;

  afm_entry_t ent_q, ent_d, init_ent;

  // Fresh model value for this position.
  always_comb begin
    init_ent.freq = (idx_i == '0) ? '0 : CNT_W'(1);
    init_ent.cum  = CNT_W'(SYMBOL_COUNT) - CNT_W'(idx_i);
    init_ent.chr  = (idx_i == '0) ? '0 : CHR_W'(idx_i - IDX_W'(1));
  end

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.init) begin
      ent_d = init_ent;
    end else if (ctrl_i.shift) begin
      ent_d = ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

[src/adaptive_frequency_model_core.sv]
// Top level: adaptive frequency model built as a rotating ring of entry cells.
// Every pass rotates the ring once through all cells. Update: a find pass, an apply pass,
//   then the character map writes; a halving pass runs first when the total hits the limit.
// Lookup: a map read, then a read pass. Reinitialise, bad request: no ring pass.
// Throughput: one item at a time; the ring pass length sets the rate.
// Reset: asynchronous, active low; the init state after reset loads the fresh model.
`default_nettype none
module adaptive_frequency_model_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire afm_pkg::afm_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output afm_pkg::afm_out_t     out_data_o
);
  import afm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_COUNT);

  afm_state_e state_q, state_d;

  // Ring: cell i takes from cell i+1, the head (cell 0) feeds the tail.
  afm_entry_t     cell_o [NUM_CELLS];
  afm_entry_t     cell_in[NUM_CELLS];
  afm_entry_t     head, wb;
  afm_cell_ctrl_t ctrl;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == NUM_CELLS - 1) begin : g_tail
      assign cell_in[i] = wb;
    end else begin : g_body
      assign cell_in[i] = cell_o[i+1];
    end
    afm_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .idx_i  (IDX_W'(i)),
      .ent_i  (cell_in[i]),
      .ent_o  (cell_o[i])
    );
  end

  assign head = cell_o[0];

  // Character to index map; valid bit clear means the index is taken as char + 1.
  logic [IDX_W-1:0]      c2i_mem [CHAR_COUNT];
  logic [CHAR_COUNT-1:0] c2i_vld_q;
  logic [IDX_W-1:0]      rd_q;
  logic                  rdv_q;
  logic                  mem_we;
  logic [CHAR_W-1:0]     mem_wa;
  logic [IDX_W-1:0]      mem_wd;

  // Per-item working registers.
  logic [IDX_W-1:0] k_q;          // index at the head during a pass
  logic [IDX_W-1:0] sym_q, pos_q, run_start_q, idx_q;
  logic [CHR_W-1:0] cpos_q, csym_q, run_chr_q;
  logic [CHAR_W-1:0] chr_q;
  logic [CNT_W-1:0] prev_f_q, acc_q, total_q, lo_q, hi_q;
  logic             rescale_q, bad_q, init_rsp_q;
  afm_out_t         out_q;
  logic             out_valid_q;

  logic             last, accept, out_load, new_run;
  logic [CNT_W-1:0] half_f;
  logic [IDX_W-1:0] k_inc, cur_start, look_idx;
  logic [CHR_W-1:0] cur_chr;
  logic             swap;

  assign last      = (k_q == LAST_IDX);
  assign k_inc     = k_q + IDX_W'(1);
  assign accept    = in_valid_i && !in_stall_o;
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign half_f    = CNT_W'(({1'b0, head.freq} + (CNT_W+1)'(1)) >> 1);
  assign new_run   = (k_q == '0) || (head.freq != prev_f_q);
  assign cur_start = new_run ? k_q : run_start_q;
  assign cur_chr   = new_run ? head.chr : run_chr_q;
  assign swap      = (pos_q != sym_q);
  assign look_idx  = rdv_q ? rd_q : (IDX_W'(chr_q) + IDX_W'(1));

  // Head write-back: the entry leaving the head re-enters at the tail.
  always_comb begin
    wb = head;
    case (state_q)
      ST_HALVE: wb.freq = half_f;
      ST_FIND: begin
        if (rescale_q) begin
          wb.cum = total_q - (acc_q + head.freq);
        end
      end
      ST_APPLY: begin
        if (k_q < pos_q) begin
          wb.cum = head.cum + CNT_W'(1);
        end
        if (k_q == pos_q) begin
          wb.freq = head.freq + CNT_W'(1);
          wb.chr  = csym_q;
        end else if (k_q == sym_q) begin
          wb.chr = cpos_q;
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: state_d = init_rsp_q ? ST_OUT : ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.action)
            ACT_UPDATE: begin
              if (in_data_i.symbol_index == '0 || in_data_i.symbol_index > LAST_IDX) begin
                state_d = ST_OUT;
              end else if (total_q >= CNT_W'(FREQ_LIMIT)) begin
                state_d = ST_HALVE;
              end else begin
                state_d = ST_FIND;
              end
            end
            ACT_LOOKUP: begin
              if ({1'b0, in_data_i.char_value} >= CHR_W'(CHAR_COUNT)) begin
                state_d = ST_OUT;
              end else begin
                state_d = ST_LOOK;
              end
            end
            ACT_REINIT: state_d = ST_INIT;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_LOOK:  state_d = (look_idx == '0 || look_idx > LAST_IDX) ? ST_OUT : ST_READ;
      ST_HALVE: state_d = last ? ST_FIND : ST_HALVE;
      ST_FIND:  state_d = last ? ST_APPLY : ST_FIND;
      ST_APPLY: state_d = last ? ST_WR1 : ST_APPLY;
      ST_READ:  state_d = last ? ST_OUT : ST_READ;
      ST_WR1:   state_d = ST_WR2;
      ST_WR2:   state_d = ST_OUT;
      ST_OUT:   state_d = out_load ? ST_IDLE : ST_OUT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ctrl.init  = (state_q == ST_INIT);
    ctrl.shift = (state_q == ST_HALVE) || (state_q == ST_FIND) ||
                 (state_q == ST_APPLY) || (state_q == ST_READ);
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    unique case (state_q)
      ST_WR1: begin
        mem_we = swap && (cpos_q < CHR_W'(CHAR_COUNT));
        mem_wa = CHAR_W'(cpos_q);
        mem_wd = sym_q;
      end
      ST_WR2: begin
        mem_we = swap && (csym_q < CHR_W'(CHAR_COUNT));
        mem_wa = CHAR_W'(csym_q);
        mem_wd = pos_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_rsp_q  <= 1'b0;
      k_q         <= '0;
      c2i_vld_q   <= '0;
      out_valid_q <= 1'b0;
      total_q     <= CNT_W'(SYMBOL_COUNT);
    end else begin
      state_q <= state_d;
      if (ctrl.shift) begin
        k_q <= last ? '0 : k_inc;
      end
      if (state_q == ST_INIT) begin
        c2i_vld_q <= '0;
        total_q   <= CNT_W'(SYMBOL_COUNT);
        init_rsp_q <= 1'b0;
      end else if (accept && in_data_i.action == ACT_REINIT) begin
        init_rsp_q <= 1'b1;
      end
      if (mem_we) begin
        c2i_vld_q[mem_wa] <= 1'b1;
      end
      if (state_q == ST_HALVE && last) begin
        total_q <= acc_q + half_f;
      end
      if (state_q == ST_APPLY && last) begin
        total_q <= total_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      c2i_mem[mem_wa] <= mem_wd;
    end
    rd_q  <= c2i_mem[in_data_i.char_value];
    rdv_q <= c2i_vld_q[in_data_i.char_value];

    if (accept) begin
      sym_q     <= in_data_i.symbol_index;
      chr_q     <= in_data_i.char_value;
      rescale_q <= (total_q >= CNT_W'(FREQ_LIMIT));
      idx_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      acc_q     <= '0;
      bad_q     <= !(in_data_i.action == ACT_REINIT || in_data_i.action == ACT_UPDATE ||
                     in_data_i.action == ACT_LOOKUP) ||
                   (in_data_i.action == ACT_UPDATE &&
                    (in_data_i.symbol_index == '0 || in_data_i.symbol_index > LAST_IDX)) ||
                   (in_data_i.action == ACT_LOOKUP &&
                    {1'b0, in_data_i.char_value} >= CHR_W'(CHAR_COUNT));
    end

    case (state_q)
      ST_LOOK: begin
        if (look_idx == '0 || look_idx > LAST_IDX) begin
          bad_q <= 1'b1;
        end else begin
          idx_q <= look_idx;
        end
      end
      ST_HALVE: acc_q <= last ? '0 : acc_q + half_f;
      ST_FIND: begin
        acc_q       <= acc_q + head.freq;
        prev_f_q    <= head.freq;
        run_start_q <= cur_start;
        run_chr_q   <= cur_chr;
        if (k_q == sym_q) begin
          pos_q  <= cur_start;
          cpos_q <= cur_chr;
          csym_q <= head.chr;
        end
      end
      ST_APPLY: begin
        if (k_inc == pos_q) begin
          hi_q <= head.cum + CNT_W'(1);
        end
        if (k_q == pos_q) begin
          lo_q <= head.cum;
        end
        idx_q <= pos_q;
      end
      ST_READ: begin
        if (k_inc == idx_q) begin
          hi_q <= head.cum;
        end
        if (k_q == idx_q) begin
          lo_q <= head.cum;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_q.index_out   <= idx_q;
      out_q.cum_low     <= lo_q;
      out_q.cum_high    <= hi_q;
      out_q.total_count <= total_q;
      out_q.bad_request <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The model total never passes the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(FREQ_LIMIT))
    else $error("model total above limit");

  // Outside a pass the ring is aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> k_q == '0)
    else $error("ring misaligned at idle");

  // Update target lies in 1..sym.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_APPLY |-> (pos_q <= sym_q && pos_q != '0))
    else $error("bad update position");

  // A result beat is only loaded from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result without output state");

endmodule
`default_nettype wire
